/* design/gnd_pkg.sv */
// ----------------------------------------------------------------------------
// Gauge needle driver package
// Shared types, register indexes, reset values and the constant divider.
// ----------------------------------------------------------------------------
package gnd_pkg;

   localparam int ANGLE_W    = 11;
   localparam int SPEED_W    = 12;
   localparam int SLOPE_W    = 20;
   localparam int SLOPE_MAG_W = 18;
   localparam int PROD_W     = 30;
   localparam int QUOT_W     = 24;
   localparam int ZONE_W     = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int NUM_ZONES  = 4;

   localparam logic [CSR_IDX_W-1:0] REG_ARC_START   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ARC_END     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_SCALE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ALERT_SPEED = 2'd3;

   localparam logic OP_SPEED = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [ZONE_W-1:0] ZONE_GREEN       = 3'd0;
   localparam logic [ZONE_W-1:0] ZONE_LIGHT_GREEN = 3'd1;
   localparam logic [ZONE_W-1:0] ZONE_YELLOW      = 3'd2;
   localparam logic [ZONE_W-1:0] ZONE_ORANGE      = 3'd3;
   localparam logic [ZONE_W-1:0] ZONE_RED         = 3'd4;

   localparam logic signed [ANGLE_W-1:0] ARC_START_RST = 11'sd0;
   localparam logic signed [ANGLE_W-1:0] ARC_END_RST   = 11'sd270;
   localparam logic [SPEED_W-1:0] FULL_SCALE_RST  = 12'd300;
   localparam logic [SPEED_W-1:0] ALERT_SPEED_RST = 12'd280;
   localparam logic [SPEED_W-1:0] LAST_SPEED_RST  = 12'd1;

   localparam logic signed [SPEED_W-1:0] STEP_CAP  = 12'sd8;
   localparam logic signed [SPEED_W-1:0] SNAP_DIST = 12'sd2;

   // x / 100 is (x / 4) / 25; x / 25 is a reciprocal multiply, exact for 28-bit x.
   localparam logic [28:0] RECIP_25       = 29'd343597384;
   localparam int          RECIP_25_SHIFT = 33;

   typedef struct packed {
      logic                op;
      logic [SPEED_W-1:0]  speed_sample;
   } req_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] needle_angle;
      logic [ZONE_W-1:0]         colour_zone;
      logic                      alert_pulse;
      logic                      still_moving;
   } rsp_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0]          arc_start_deg;
      logic signed [ANGLE_W-1:0]          arc_end_deg;
      logic [SPEED_W-1:0]                 alert_speed;
      logic signed [SLOPE_W-1:0]          angle_slope;
      logic [NUM_ZONES-1:0][ANGLE_W-1:0]  zone_angles;
   } cfg_type;

   typedef struct packed {
      logic                      op;
      logic [SPEED_W-1:0]        speed;
      logic signed [ANGLE_W-1:0] target;
   } item_type;

   function automatic logic [QUOT_W-1:0] div100(input logic [PROD_W-1:0] x);
      logic [56:0] p;
      p = 57'(x[PROD_W-1:2]) * 57'(RECIP_25);
      return p[56:RECIP_25_SHIFT];
   endfunction

endpackage

/* design/gnd_derive.sv */
// ----------------------------------------------------------------------------
// Gauge needle driver configuration and derivation
// Holds the configuration registers and derives the slope with a bit-serial
// divider, then the four colour-zone boundary angles one after another.
// ----------------------------------------------------------------------------
module gnd_derive (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gnd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gnd_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                              busy,
   output gnd_pkg::cfg_type                  cfg
);
   import gnd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_ZMUL = 2'd2;
   localparam logic [1:0] ST_ZSAT = 2'd3;
   localparam int DIV_STEPS = 18;

   logic signed [ANGLE_W-1:0] arc_start_ff, arc_end_ff;
   logic [SPEED_W-1:0]        full_scale_ff, alert_speed_ff;
   logic [1:0]                state_ff;
   logic [4:0]                cnt_ff;
   logic [SPEED_W-1:0]        rem_ff, rem_in;
   logic [SLOPE_MAG_W-1:0]    quo_ff, quo_in;
   logic signed [SLOPE_W-1:0] slope_ff, slope_in;
   logic [NUM_ZONES-1:0][ANGLE_W-1:0] zone_ff;
   logic [1:0]                zsel_ff;
   logic [PROD_W-1:0]         zprod_ff, zprod_in;

   logic [SPEED_W-1:0]        fs_eff;
   logic signed [SPEED_W-1:0] diff;
   logic [SPEED_W-1:0]        diff_abs;
   logic [SLOPE_MAG_W-1:0]    num;
   logic [SPEED_W:0]          trial, trial_sub;
   logic                      ge;
   logic [SPEED_W-1:0]        half;
   logic [19:0]               part_prod;
   logic [8:0]                part;
   logic [SPEED_W-1:0]        zspd;
   logic [SLOPE_W-1:0]        slope_neg;
   logic [SLOPE_MAG_W-1:0]    slope_mag;
   logic [QUOT_W-1:0]         zq;
   logic signed [QUOT_W:0]    zoff;
   logic signed [QUOT_W+1:0]  zsum;
   logic [ANGLE_W-1:0]        zsat;
   logic                      wr;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !busy;
   assign wr        = csr_valid && csr_ready;

   always_comb begin
      fs_eff    = (full_scale_ff == '0) ? 12'd1 : full_scale_ff;
      diff      = {arc_end_ff[ANGLE_W-1], arc_end_ff} - {arc_start_ff[ANGLE_W-1], arc_start_ff};
      diff_abs  = diff[SPEED_W-1] ? 12'(-diff) : diff;
      num       = (18'(diff_abs) << 6) + (18'(diff_abs) << 5) + (18'(diff_abs) << 2);
      trial     = {rem_ff, num[5'(DIV_STEPS-1) - cnt_ff]};
      ge        = (trial >= {1'b0, fs_eff});
      trial_sub = trial - {1'b0, fs_eff};
      rem_in    = ge ? trial_sub[SPEED_W-1:0] : trial[SPEED_W-1:0];
      quo_in    = {quo_ff[SLOPE_MAG_W-2:0], ge};
      slope_in  = diff[SPEED_W-1] ? -$signed({2'b00, quo_in}) : $signed({2'b00, quo_in});

      half      = fs_eff >> 1;
      part_prod = 20'(fs_eff[SPEED_W-1:2]) * 20'd683;
      part      = part_prod[19:11];
      case (zsel_ff)
         2'd0:    zspd = half;
         2'd1:    zspd = half + 12'({part, 1'b0});
         2'd2:    zspd = half + 12'({part, 2'b00});
         default: zspd = half + 12'({part, 2'b00}) + 12'(part);
      endcase
      slope_neg = -slope_ff;
      slope_mag = slope_ff[SLOPE_W-1] ? slope_neg[SLOPE_MAG_W-1:0]
                                      : slope_ff[SLOPE_MAG_W-1:0];
      zprod_in  = PROD_W'(zspd) * PROD_W'(slope_mag);

      zq        = div100(zprod_ff);
      zoff      = slope_ff[SLOPE_W-1] ? -$signed({1'b0, zq}) : $signed({1'b0, zq});
      zsum      = {zoff[QUOT_W], zoff} + {{(QUOT_W+2-ANGLE_W){arc_start_ff[ANGLE_W-1]}},
                                          arc_start_ff};
      if (zsum > 26'sd1023) begin
         zsat = 11'sd1023;
      end else if (zsum < -26'sd1024) begin
         zsat = -11'sd1024;
      end else begin
         zsat = zsum[ANGLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arc_start_ff   <= ARC_START_RST;
         arc_end_ff     <= ARC_END_RST;
         full_scale_ff  <= FULL_SCALE_RST;
         alert_speed_ff <= ALERT_SPEED_RST;
         state_ff       <= ST_DIV;
         cnt_ff         <= '0;
         rem_ff         <= '0;
         zsel_ff        <= '0;
      end else if (wr) begin
         unique case (csr_index)
            REG_ARC_START:   arc_start_ff   <= csr_data[ANGLE_W-1:0];
            REG_ARC_END:     arc_end_ff     <= csr_data[ANGLE_W-1:0];
            REG_FULL_SCALE:  full_scale_ff  <= csr_data;
            REG_ALERT_SPEED: alert_speed_ff <= csr_data;
         endcase
         state_ff <= ST_DIV;
         cnt_ff   <= '0;
         rem_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
            end
            ST_DIV: begin
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(DIV_STEPS-1)) begin
                  state_ff <= ST_ZMUL;
                  zsel_ff  <= '0;
               end
            end
            ST_ZMUL: begin
               state_ff <= ST_ZSAT;
            end
            ST_ZSAT: begin
               zsel_ff  <= zsel_ff + 2'd1;
               state_ff <= (zsel_ff == 2'(NUM_ZONES-1)) ? ST_IDLE : ST_ZMUL;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV) begin
         quo_ff <= quo_in;
         if (cnt_ff == 5'(DIV_STEPS-1)) begin
            slope_ff <= slope_in;
         end
      end
      if (state_ff == ST_ZMUL) begin
         zprod_ff <= zprod_in;
      end
      if (state_ff == ST_ZSAT) begin
         zone_ff[zsel_ff] <= zsat;
      end
   end

   always_comb begin
      cfg.arc_start_deg = arc_start_ff;
      cfg.arc_end_deg   = arc_end_ff;
      cfg.alert_speed   = alert_speed_ff;
      cfg.angle_slope   = slope_ff;
      cfg.zone_angles   = zone_ff;
   end

endmodule

/* design/gnd_target_pipe.sv */
// ----------------------------------------------------------------------------
// Gauge needle driver target pipeline
// Registers each input item, multiplies the speed by the slope, divides by
// one hundred and clamps the resulting target angle to the arc.
// ----------------------------------------------------------------------------
module gnd_target_pipe (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  gnd_pkg::req_type   req_payload,
   input  logic               busy,
   input  gnd_pkg::cfg_type   cfg,
   output logic               item_valid,
   input  logic               item_ready,
   output gnd_pkg::item_type  item
);
   import gnd_pkg::*;

   logic                      v1_ff, v2_ff, v3_ff;
   logic                      rdy1, rdy2, rdy3, accept;
   req_type                   s1_ff;
   logic                      s2_op_ff, s2_neg_ff;
   logic [SPEED_W-1:0]        s2_speed_ff;
   logic [PROD_W-1:0]         s2_prod_ff, s2_prod_in;
   item_type                  s3_ff, s3_in;

   logic [SLOPE_W-1:0]        slope_neg;
   logic [SLOPE_MAG_W-1:0]    slope_mag;
   logic [QUOT_W-1:0]         q;
   logic signed [QUOT_W:0]    off;
   logic signed [QUOT_W+1:0]  t, start_x, end_x;

   assign rdy3      = !v3_ff || item_ready;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = busy || !rdy1;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      slope_neg  = -cfg.angle_slope;
      slope_mag  = cfg.angle_slope[SLOPE_W-1] ? slope_neg[SLOPE_MAG_W-1:0]
                                              : cfg.angle_slope[SLOPE_MAG_W-1:0];
      s2_prod_in = PROD_W'(s1_ff.speed_sample) * PROD_W'(slope_mag);

      q       = div100(s2_prod_ff);
      off     = s2_neg_ff ? -$signed({1'b0, q}) : $signed({1'b0, q});
      start_x = {{(QUOT_W+2-ANGLE_W){cfg.arc_start_deg[ANGLE_W-1]}}, cfg.arc_start_deg};
      end_x   = {{(QUOT_W+2-ANGLE_W){cfg.arc_end_deg[ANGLE_W-1]}}, cfg.arc_end_deg};
      t       = {off[QUOT_W], off} + start_x;
      s3_in.op    = s2_op_ff;
      s3_in.speed = s2_speed_ff;
      if (t < start_x) begin
         s3_in.target = cfg.arc_start_deg;
      end else if (t > end_x) begin
         s3_in.target = cfg.arc_end_deg;
      end else begin
         s3_in.target = t[ANGLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= accept;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= req_payload;
      end
      if (rdy2 && v1_ff) begin
         s2_op_ff    <= s1_ff.op;
         s2_speed_ff <= s1_ff.speed_sample;
         s2_neg_ff   <= cfg.angle_slope[SLOPE_W-1];
         s2_prod_ff  <= s2_prod_in;
      end
      if (rdy3 && v2_ff) begin
         s3_ff <= s3_in;
      end
   end

   assign item_valid = v3_ff;
   assign item       = s3_ff;

endmodule

/* design/gnd_needle.sv */
// ----------------------------------------------------------------------------
// Gauge needle driver needle state and result register
// Applies the speed change and overspeed alert, takes one easing step on a
// tick or a speed change, classifies the colour zone and holds the result
// until it is transferred.
module gnd_needle (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   output logic               item_ready,
   input  gnd_pkg::item_type  item,
   input  gnd_pkg::cfg_type   cfg,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output gnd_pkg::rsp_type   rsp_payload
);
   import gnd_pkg::*;

   logic [SPEED_W-1:0]        last_speed_ff, last_speed_in;
   logic                      armed_off_ff, armed_off_in;
   logic signed [ANGLE_W-1:0] target_ff, target_in;
   logic signed [ANGLE_W-1:0] current_ff, current_in;
   logic                      rsp_valid_ff;
   rsp_type                   rsp_ff, rsp_in;

   logic                      take, is_speed, changed, pulse, do_ease;
   logic signed [SPEED_W-1:0] d, nd, inc, step, cur_sum;

   assign item_ready = !rsp_valid_ff || !rsp_stall;
   assign take       = item_valid && item_ready;

   always_comb begin
      is_speed      = (item.op == OP_SPEED);
      changed       = is_speed && (item.speed != last_speed_ff);
      do_ease       = changed || !is_speed;
      last_speed_in = changed ? item.speed : last_speed_ff;
      target_in     = changed ? item.target : target_ff;
      pulse         = 1'b0;
      armed_off_in  = armed_off_ff;
      if (changed) begin
         if ((cfg.alert_speed != '0) && !armed_off_ff && (item.speed >= cfg.alert_speed)) begin
            armed_off_in = 1'b1;
            pulse        = 1'b1;
         end else if (armed_off_ff && (item.speed < cfg.alert_speed)) begin
            armed_off_in = 1'b0;
         end
      end

      d  = $signed({target_in[ANGLE_W-1], target_in}) - $signed({current_ff[ANGLE_W-1], current_ff});
      nd = -d;
      if (d >= SNAP_DIST) begin
         inc  = d >>> 1;
         step = (inc > STEP_CAP) ? STEP_CAP : inc;
      end else if (d <= -SNAP_DIST) begin
         inc  = nd >>> 1;
         step = (inc > STEP_CAP) ? -STEP_CAP : -inc;
      end else begin
         inc  = d;
         step = d;
      end
      cur_sum    = $signed({current_ff[ANGLE_W-1], current_ff}) + step;
      current_in = do_ease ? cur_sum[ANGLE_W-1:0] : current_ff;

      rsp_in.needle_angle = current_in;
      rsp_in.alert_pulse  = pulse;
      rsp_in.still_moving = (current_in != target_in);
      if (current_in > $signed(cfg.zone_angles[3])) begin
         rsp_in.colour_zone = ZONE_RED;
      end else if (current_in > $signed(cfg.zone_angles[2])) begin
         rsp_in.colour_zone = ZONE_ORANGE;
      end else if (current_in > $signed(cfg.zone_angles[1])) begin
         rsp_in.colour_zone = ZONE_YELLOW;
      end else if (current_in > $signed(cfg.zone_angles[0])) begin
         rsp_in.colour_zone = ZONE_LIGHT_GREEN;
      end else begin
         rsp_in.colour_zone = ZONE_GREEN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_speed_ff <= LAST_SPEED_RST;
         armed_off_ff  <= 1'b0;
         target_ff     <= ARC_START_RST;
         current_ff    <= ARC_START_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (item_ready) begin
            rsp_valid_ff <= item_valid;
         end
         if (take) begin
            last_speed_ff <= last_speed_in;
            armed_off_ff  <= armed_off_in;
            target_ff     <= target_in;
            current_ff    <= current_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* design/gauge_needle_driver_core.sv */
// ----------------------------------------------------------------------------
// Gauge needle driver core
// Speedometer needle with eased motion, colour zones and a one-shot
// overspeed alert.
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/stall     op, speed_sample
//   rsp      out        rsp_valid/stall     needle_angle, colour_zone,
//                                           alert_pulse, still_moving
//   csr      in         csr_valid/ready     csr_index, csr_data
//
// One item is taken per cycle when req_stall is low; each result passes
// through the input, product, quotient and result registers in turn.
// After reset, and after every register write, the slope divider and zone
// derivation run, during which req_stall and not csr_ready are held. A
// stalled result holds the last stage; earlier stages keep filling until
// the pipeline is full.
// ----------------------------------------------------------------------------
module gauge_needle_driver_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  gnd_pkg::req_type                  req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output gnd_pkg::rsp_type                  rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gnd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gnd_pkg::CSR_DATA_W-1:0]    csr_data
);
   import gnd_pkg::*;

   cfg_type  cfg;
   item_type item;
   logic     busy, item_valid, item_ready;

   gnd_derive u_derive (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .busy      (busy),
      .cfg       (cfg)
   );

   gnd_target_pipe u_target_pipe (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .busy        (busy),
      .cfg         (cfg),
      .item_valid  (item_valid),
      .item_ready  (item_ready),
      .item        (item)
   );

   gnd_needle u_needle (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item_ready  (item_ready),
      .item        (item),
      .cfg         (cfg),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
